/* src/skt_pkg.sv */
`timescale 1ns / 1ps
package skt_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int KEY_W         = 32;
  localparam int PAY_W         = 32;
  localparam int REQ_W         = 3;
  localparam int IDX_W         = 6;
  localparam int CNT_OUT_W     = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SHUP = 6'b000100,
    S_SHDN = 6'b001000,
    S_PUT  = 6'b010000,
    S_READ = 6'b100000
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

/* src/sorted_key_table_unit.sv */
`timescale 1ns / 1ps
// Sorted key table: up to TABLE_DEPTH records, inserted in order of a signed
// 32-bit key, each with a 32-bit payload word; a key change does not reorder.
// Request channel: in_req_type, in_key, in_new_key, in_payload, in_index are
// taken at a rising edge with start high and busy low. busy stays high while
// the request works; no other request is taken meanwhile.
// Result channel: one result per request, shown for exactly one cycle with
// out_strobe high; the receiver cannot stall and must take it then.
// Steps from the accepting edge to the strobe cycle:
//   status query, full insert, miss on empty table: reported from idle
//   read at index: one read state
//   insert: forward scan, shift up, final write (write only if empty)
//   delete: scan to the match, shift down
//   change key: scan to the match, rewrite in place
// The steps are set by the single memory read port and the one shared key
// compare: one entry is scanned or moved per cycle.
// Reset (rst_n low, synchronous) empties the table; the entry memory is not
// cleared, since only entries below the count are ever used.
module sorted_key_table_unit #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [skt_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [skt_pkg::KEY_W-1:0]  in_key,
  input  logic signed [skt_pkg::KEY_W-1:0]  in_new_key,
  input  logic [skt_pkg::PAY_W-1:0]         in_payload,
  input  logic [skt_pkg::IDX_W-1:0]         in_index,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic [skt_pkg::CNT_OUT_W-1:0]     out_entry_count,
  output logic                              out_is_full,
  output logic                              out_is_empty,
  output logic signed [skt_pkg::KEY_W-1:0]  out_read_key,
  output logic [skt_pkg::PAY_W-1:0]         out_read_payload
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [KEY_W-1:0] cmp_key;
  cmp_res_t                cmp_res;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic                    wr_en;
  entry_t                  rd_data;
  entry_t                  wr_data;
  status_t                 status;

  skt_cmp u_cmp (
    .cmp_a   (cmp_key),
    .cmp_b   (rd_data.key),
    .cmp_res (cmp_res)
  );

  skt_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_new_key       (in_new_key),
    .in_payload       (in_payload),
    .in_index         (in_index),
    .cmp_key          (cmp_key),
    .cmp_res          (cmp_res),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .out_strobe       (out_strobe),
    .out_status       (status),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty),
    .out_read_key     (out_read_key),
    .out_read_payload (out_read_payload)
  );

  assign out_status = status;

`ifndef SYNTH
  // an accepted request either keeps the block busy or reports at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request neither busy nor reported");

  // read data shows only on a successful request
  a_read_data_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_read_key != '0 || out_read_payload != '0))
      |-> (status == ST_DONE))
    else $error("read data on a failed request");

  // a refused insert reports a full table
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && status == ST_FULL) |-> out_is_full)
    else $error("table full status without full flag");

  // no write to the table while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !wr_en)
    else $error("table write while idle");
`endif

endmodule

/* src/skt_cmp.sv */
`timescale 1ns / 1ps
module skt_cmp (
  input  logic signed [skt_pkg::KEY_W-1:0] cmp_a,
  input  logic signed [skt_pkg::KEY_W-1:0] cmp_b,
  output skt_pkg::cmp_res_t                cmp_res
);
  import skt_pkg::*;

  // signed greater-than and equality compare of the request key with an entry
  assign cmp_res.gt = (cmp_a > cmp_b);
  assign cmp_res.eq = (cmp_a == cmp_b);

endmodule

/* src/skt_mem.sv */
`timescale 1ns / 1ps
module skt_mem #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH,
  parameter int AW          = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  skt_pkg::entry_t     wr_data,
  input  logic [AW-1:0]       rd_addr,
  output skt_pkg::entry_t     rd_data
);
  import skt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  // write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/skt_seq.sv */
`timescale 1ns / 1ps
module skt_seq #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH,
  parameter int AW          = 6,
  parameter int CNT_W       = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [skt_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [skt_pkg::KEY_W-1:0]   in_key,
  input  logic signed [skt_pkg::KEY_W-1:0]   in_new_key,
  input  logic [skt_pkg::PAY_W-1:0]          in_payload,
  input  logic [skt_pkg::IDX_W-1:0]          in_index,
  output logic signed [skt_pkg::KEY_W-1:0]   cmp_key,
  input  skt_pkg::cmp_res_t                  cmp_res,
  output logic [AW-1:0]                      rd_addr,
  input  skt_pkg::entry_t                    rd_data,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output skt_pkg::entry_t                    wr_data,
  output logic                               out_strobe,
  output skt_pkg::status_t                   out_status,
  output logic [skt_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic                               out_is_full,
  output logic                               out_is_empty,
  output logic signed [skt_pkg::KEY_W-1:0]   out_read_key,
  output logic [skt_pkg::PAY_W-1:0]          out_read_payload
);
  import skt_pkg::*;

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  state_t                  state_r, state_nxt;
  logic [REQ_W-1:0]        req_r;
  logic signed [KEY_W-1:0] key_r, nkey_r;
  logic [PAY_W-1:0]        pay_r;
  logic [CMP_W-1:0]        idx_r;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    acc;
  logic                    hit;
  logic                    last;
  logic [CMP_W-1:0]        rd_sel;
  logic [CMP_W-1:0]        in_idx_ext;
  logic                    fin;
  status_t                 fin_status;
  logic signed [KEY_W-1:0] fin_rkey;
  logic [PAY_W-1:0]        fin_rpay;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  logic                    out_strobe_r;
  status_t                 out_status_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic                    out_full_r;
  logic                    out_empty_r;
  logic signed [KEY_W-1:0] out_rkey_r;
  logic [PAY_W-1:0]        out_rpay_r;

  assign busy       = (state_r != S_IDLE);
  assign acc        = start && !busy;
  assign cmp_key    = key_r;
  assign in_idx_ext = CMP_W'(in_index);
  assign rd_addr    = rd_sel[AW-1:0];
  // insert stops at the first key not below it, delete and change at an equal key
  assign hit        = (req_r == REQ_INSERT) ? !cmp_res.gt : cmp_res.eq;
  assign last       = ((ptr_r + ONE) == count_r);
  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, count_nxt};

  // sequence scan, shift and write steps over the shared compare and memory port
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    rd_sel     = CMP_W'(ptr_r + ONE);
    wr_en      = 1'b0;
    wr_addr    = ptr_r[AW-1:0];
    wr_data    = rd_data;
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_rkey   = '0;
    fin_rpay   = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_sel = (in_req_type == REQ_READ) ? in_idx_ext : '0;
        if (acc) begin
          if (in_req_type == REQ_INSERT) begin
            if (count_r == FULL) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (count_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PUT;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else if (in_req_type == REQ_DELETE || in_req_type == REQ_CHANGE) begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_NOT_FOUND;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else if (in_req_type == REQ_READ) begin
            state_nxt = S_READ;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (req_r == REQ_INSERT) begin
            pos_nxt   = ptr_r;
            ptr_nxt   = count_r;
            rd_sel    = CMP_W'(count_r - ONE);
            state_nxt = S_SHUP;
          end else if (req_r == REQ_DELETE) begin
            if (last) begin
              fin       = 1'b1;
              count_nxt = count_r - ONE;
            end else begin
              state_nxt = S_SHDN;
            end
          end else begin
            // rewrite the key in place, keep the payload just read
            wr_en           = 1'b1;
            wr_data.key     = nkey_r;
            wr_data.payload = rd_data.payload;
            fin             = 1'b1;
          end
        end else if (last) begin
          if (req_r == REQ_INSERT) begin
            pos_nxt   = count_r;
            state_nxt = S_PUT;
          end else begin
            fin        = 1'b1;
            fin_status = ST_NOT_FOUND;
          end
        end else begin
          ptr_nxt = ptr_r + ONE;
        end
      end
      S_SHUP: begin
        // move entry ptr-1 up to ptr, fetch the one below it
        wr_en  = 1'b1;
        rd_sel = CMP_W'(ptr_r - TWO);
        if (ptr_r == (pos_r + ONE)) begin
          state_nxt = S_PUT;
        end else begin
          ptr_nxt = ptr_r - ONE;
        end
      end
      S_SHDN: begin
        // move entry ptr+1 down to ptr, fetch the one after it
        wr_en  = 1'b1;
        rd_sel = CMP_W'(ptr_r + TWO);
        if ((ptr_r + TWO) == count_r) begin
          fin       = 1'b1;
          count_nxt = count_r - ONE;
        end else begin
          ptr_nxt = ptr_r + ONE;
        end
      end
      S_PUT: begin
        wr_en           = 1'b1;
        wr_addr         = pos_r[AW-1:0];
        wr_data.key     = key_r;
        wr_data.payload = pay_r;
        count_nxt       = count_r + ONE;
        fin             = 1'b1;
      end
      S_READ: begin
        fin = 1'b1;
        if (idx_r < CMP_W'(count_r)) begin
          fin_rkey = rd_data.key;
          fin_rpay = rd_data.payload;
        end else begin
          fin_status = ST_RANGE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  // advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= fin;
    end
  end

  // hold the request and the scan pointers
  always_ff @(posedge clk) begin
    if (acc) begin
      req_r  <= in_req_type;
      key_r  <= in_key;
      nkey_r <= in_new_key;
      pay_r  <= in_payload;
      idx_r  <= in_idx_ext;
    end
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
  end

  // load the result for a one-cycle transfer
  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= fin_status;
      out_count_r  <= cnt_ext[CNT_OUT_W-1:0];
      out_full_r   <= (count_nxt == FULL);
      out_empty_r  <= (count_nxt == '0);
      out_rkey_r   <= fin_rkey;
      out_rpay_r   <= fin_rpay;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_is_full      = out_full_r;
  assign out_is_empty     = out_empty_r;
  assign out_read_key     = out_rkey_r;
  assign out_read_payload = out_rpay_r;

endmodule

/* dv/sorted_key_table_unit_test.sv */
`timescale 1ns / 1ps
module sorted_key_table_unit_test;
  import skt_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 100;

  // request codes beyond the package set: status query and the spare codes
  localparam logic [REQ_W-1:0] REQ_STATUS = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]        kind;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] new_key;
    logic [PAY_W-1:0]        payload;
    logic [IDX_W-1:0]        index;
  } request_t;

  typedef struct {
    status_t                 status;
    logic [CNT_OUT_W-1:0]    count;
    logic                    full;
    logic                    empty;
    logic signed [KEY_W-1:0] rkey;
    logic [PAY_W-1:0]        rpay;
  } reply_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [REQ_W-1:0]        in_req_type = REQ_STATUS;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [KEY_W-1:0] in_new_key = '0;
  logic [PAY_W-1:0]        in_payload = '0;
  logic [IDX_W-1:0]        in_index = '0;
  logic                    out_strobe;
  logic [1:0]              out_status;
  logic [CNT_OUT_W-1:0]    out_entry_count;
  logic                    out_is_full;
  logic                    out_is_empty;
  logic signed [KEY_W-1:0] out_read_key;
  logic [PAY_W-1:0]        out_read_payload;

  sorted_key_table_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_key(in_key), .in_new_key(in_new_key),
    .in_payload(in_payload), .in_index(in_index),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_is_full(out_is_full),
    .out_is_empty(out_is_empty), .out_read_key(out_read_key),
    .out_read_payload(out_read_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request stream and replies owed by the block
  request_t requests_waiting[$];
  reply_t   replies_due[$];
  request_t cur_req;
  int       total_items;
  int       items_taken;
  int       mismatch_count;

  // table image kept alongside the block
  logic signed [KEY_W-1:0] tbl_key [DEPTH];
  logic [PAY_W-1:0]        tbl_pay [DEPTH];
  int                      tbl_count;
  int                      peak_count;
  int                      full_refusals;
  int                      key_misses;
  int                      range_reads;

  // keys thought present, used to aim deletes and changes at hits and reads at filled indices
  logic signed [KEY_W-1:0] live[$];

  logic signed [KEY_W-1:0] key_pool [12] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0, 32'sd1, 32'sd2,
    -32'sd2, 32'sd100, -32'sd100, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sd77
  };

  function automatic int locate_key(logic signed [KEY_W-1:0] k);
    int p;
    p = 0;
    while (p < tbl_count && tbl_key[p] != k) p++;
    return p;
  endfunction

  // apply one request to the table image and return the reply it yields
  function automatic reply_t serve_request(request_t r);
    reply_t rp;
    int     p;
    int     i;
    rp = '{status: ST_DONE, count: '0, full: 1'b0, empty: 1'b0, rkey: '0, rpay: '0};
    case (r.kind)
      REQ_INSERT: begin
        if (tbl_count >= DEPTH) begin
          rp.status = ST_FULL;
          full_refusals++;
        end else begin
          // new record lands ahead of any equal keys
          p = 0;
          while (p < tbl_count && r.key > tbl_key[p]) p++;
          for (i = tbl_count; i > p; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_pay[i] = tbl_pay[i-1];
          end
          tbl_key[p] = r.key;
          tbl_pay[p] = r.payload;
          tbl_count++;
          if (tbl_count > peak_count) peak_count = tbl_count;
        end
      end
      REQ_DELETE: begin
        p = locate_key(r.key);
        if (p >= tbl_count) begin
          rp.status = ST_NOT_FOUND;
          key_misses++;
        end else begin
          for (i = p; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
        end
      end
      REQ_CHANGE: begin
        // rewrite in place, order is not restored
        p = locate_key(r.key);
        if (p >= tbl_count) begin
          rp.status = ST_NOT_FOUND;
          key_misses++;
        end else begin
          tbl_key[p] = r.new_key;
        end
      end
      REQ_READ: begin
        if (int'(r.index) >= tbl_count) begin
          rp.status = ST_RANGE;
          range_reads++;
        end else begin
          rp.rkey = tbl_key[r.index];
          rp.rpay = tbl_pay[r.index];
        end
      end
      default: ;
    endcase
    rp.count = tbl_count[CNT_OUT_W-1:0];
    rp.full  = (tbl_count == DEPTH);
    rp.empty = (tbl_count == 0);
    return rp;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_live_or_any();
    if (live.size() > 0 && $urandom_range(0, 4) != 0)
      return live[$urandom_range(0, live.size() - 1)];
    return pick_key();
  endfunction

  // queue one request and track which keys it leaves behind
  task automatic add_request(input logic [REQ_W-1:0] kind, input logic signed [KEY_W-1:0] k,
                             input logic signed [KEY_W-1:0] nk, input logic [PAY_W-1:0] pay,
                             input logic [IDX_W-1:0] idx);
    request_t r;
    int       hit[$];
    r = '{kind: kind, key: k, new_key: nk, payload: pay, index: idx};
    requests_waiting.push_back(r);
    case (kind)
      REQ_INSERT: if (live.size() < DEPTH) live.push_back(k);
      REQ_DELETE: begin
        hit = live.find_first_index(x) with (x == k);
        if (hit.size() > 0) live.delete(hit[0]);
      end
      REQ_CHANGE: begin
        hit = live.find_first_index(x) with (x == k);
        if (hit.size() > 0) live[hit[0]] = nk;
      end
      default: ;
    endcase
  endtask

  task automatic add_random_request(input mix_t mix);
    int                      roll;
    int                      ins_lim;
    int                      del_lim;
    int                      chg_lim;
    int                      rd_lim;
    logic [IDX_W-1:0]        idx;
    logic [REQ_W-1:0]        other;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_lim = 70; del_lim = 80; chg_lim = 88; rd_lim = 96; end
      MIX_DRAIN: begin ins_lim = 15; del_lim = 70; chg_lim = 80; rd_lim = 94; end
      default:   begin ins_lim = 35; del_lim = 60; chg_lim = 75; rd_lim = 92; end
    endcase
    idx = $urandom_range(0, DEPTH - 1);
    if (live.size() > 0 && $urandom_range(0, 2) != 0) idx = $urandom_range(0, live.size() - 1);
    other = $urandom_range(REQ_STATUS, REQ_SPARE7);
    if (roll < ins_lim)
      add_request(REQ_INSERT, pick_key(), $urandom, $urandom, idx);
    else if (roll < del_lim)
      add_request(REQ_DELETE, pick_live_or_any(), $urandom, $urandom, idx);
    else if (roll < chg_lim)
      add_request(REQ_CHANGE, pick_live_or_any(), pick_key(), $urandom, idx);
    else if (roll < rd_lim)
      add_request(REQ_READ, $urandom, $urandom, $urandom, idx);
    else
      add_request(other, $urandom, $urandom, $urandom, idx);
  endtask

  // sender: bursts of back-to-back requests separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_requests
    logic take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        replies_due.push_back(serve_request(cur_req));
        items_taken++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      if (start && !take) begin
        // hold the request until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (requests_waiting.size() > 0) begin
        cur_req = requests_waiting.pop_front();
        in_req_type <= cur_req.kind;
        in_key      <= cur_req.key;
        in_new_key  <= cur_req.new_key;
        in_payload  <= cur_req.payload;
        in_index    <= cur_req.index;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: every strobe is a transfer, compare against the oldest reply owed
  always @(posedge clk) begin : watch_replies
    reply_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unrequested result, expected none actual status %0h count %0h",
                 $time, out_status, out_entry_count);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("status",       want.status, out_status);
        check_field("entry_count",  want.count,  out_entry_count);
        check_field("is_full",      want.full,   out_is_full);
        check_field("is_empty",     want.empty,  out_is_empty);
        check_field("read_key",     want.rkey,   out_read_key);
        check_field("read_payload", want.rpay,   out_read_payload);
      end
    end
  end

  initial begin
    mix_t mix;
    int   phase_len;
    int   made;
    tbl_count = 0;

    // directed: empty table, extremes, equal keys, misses, spare codes
    add_request(REQ_STATUS, 32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_DELETE, 32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_CHANGE, 32'sd0, 32'sd5, 32'h0, 6'd0);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_INSERT, 32'sd0,          32'sd0, 32'h1111_1111, 6'd0);
    add_request(REQ_INSERT, 32'sh7FFF_FFFF,  32'sd0, 32'hFFFF_FFFF, 6'd0);
    add_request(REQ_INSERT, 32'sh8000_0000,  32'sd0, 32'h0000_0000, 6'd0);
    add_request(REQ_INSERT, 32'sd0,          32'sd0, 32'h2222_2222, 6'd0);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd1);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd2);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd3);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd63);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd4);
    add_request(REQ_CHANGE, 32'sd0, 32'sh7FFF_FFFF, 32'h0, 6'd0);
    add_request(REQ_DELETE, 32'sh7FFF_FFFF, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_DELETE, 32'sd12345, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_CHANGE, 32'sd12345, 32'sd1, 32'h0, 6'd0);
    add_request(REQ_SPARE5, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    add_request(REQ_SPARE6, 32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_SPARE7, 32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd0);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd1);
    add_request(REQ_READ,   32'sd0, 32'sd0, 32'h0, 6'd2);
    add_request(REQ_INSERT, -32'sd1, 32'sd0, 32'h3333_3333, 6'd0);

    // random: phases that fill, drain or churn the table; the first one is a fill phase
    made = 0;
    mix  = MIX_FILL;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      if (made == 0) phase_len = 160;
      repeat (phase_len) add_random_request(mix);
      made += phase_len;
      mix = mix_t'($urandom_range(0, 2));
    end
    total_items = requests_waiting.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < total_items || replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d table requests; peak occupancy %0d of %0d entries.",
             items_taken, peak_count, DEPTH);
    $display("Refused inserts on full table: %0d, key misses: %0d, out-of-range reads: %0d.",
             full_refusals, key_misses, range_reads);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sorted_key_table_unit.f */
src/skt_pkg.sv
src/skt_cmp.sv
src/skt_mem.sv
src/skt_seq.sv
src/sorted_key_table_unit.sv
dv/sorted_key_table_unit_test.sv
